// File: rtl/core/sao_pkg.sv
// Shared types and constants of the scaled sprite alpha overlay.
package sao_pkg;

    localparam int SPRITE_TEXELS_DEF = 4096;
    localparam int MAX_FRAME_DIM_DEF = 4096;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int TADDR_W     = 12;
    localparam int COORD_W     = 6;
    // A covered offset stays below 64 texels times a scale of 15.
    localparam int SPAN_W      = 10;
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 14;
    localparam int IDX_W       = 12;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd6;

    localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [31:0] RGB_MASK     = 32'h00FF_FFFF;
    localparam logic [6:0]  SPRITE_DIM_MAX = 7'd64;

    typedef struct packed {
        logic                opcode;
        logic [TADDR_W-1:0]  texel_addr;
        logic [31:0]         pixel_data;
        logic                frame_start;
    } t_in_word;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        sprite_hit;
        logic        frame_end;
    } t_out_word;

    // Effective configuration: sizes and scale are already clamped on write.
    typedef struct packed {
        logic [12:0]        frame_width;
        logic [12:0]        frame_height;
        logic signed [12:0] sprite_x;
        logic signed [12:0] sprite_y;
        logic [3:0]         scale;
        logic [RECIP_W-1:0] recip;
        logic [6:0]         sprite_width;
        logic [6:0]         sprite_height;
    } t_cfg;

    typedef struct packed {
        logic               is_pix;
        logic               hit;
        logic               frame_end;
        logic [31:0]        data;
        logic [TADDR_W-1:0] taddr;
        logic [SPAN_W-1:0]  dx;
        logic [SPAN_W-1:0]  dy;
    } t_s1;

    typedef struct packed {
        logic               is_pix;
        logic               hit;
        logic               frame_end;
        logic [31:0]        data;
        logic [TADDR_W-1:0] taddr;
        logic [COORD_W-1:0] scol;
        logic [COORD_W-1:0] srow;
    } t_s2;

    typedef struct packed {
        logic        hit;
        logic        frame_end;
        logic        tex_ok;
        logic [31:0] data;
    } t_s3;

endpackage

// File: rtl/core/sao_cfg.sv
// Configuration register file with write-time clamping of sizes and scale.
module sao_cfg #(
    parameter int MAX_FRAME_DIM = sao_pkg::MAX_FRAME_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sao_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sao_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output sao_pkg::t_cfg                    o_cfg
);
    import sao_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    function automatic logic [12:0] clamp_dim(input logic [12:0] v);
        logic [12:0] res;
        if (v == 13'd0) begin
            res = 13'd1;
        end else if (32'(v) > 32'(MAX_FRAME_DIM)) begin
            res = 13'(MAX_FRAME_DIM);
        end else begin
            res = v;
        end
        return res;
    endfunction

    // ceil(2**14 / scale); exact quotients for offsets below 1024.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] sc);
        logic [RECIP_W-1:0] res;
        unique case (sc)
            4'd2:    res = 15'd8192;
            4'd3:    res = 15'd5462;
            4'd4:    res = 15'd4096;
            4'd5:    res = 15'd3277;
            4'd6:    res = 15'd2731;
            4'd7:    res = 15'd2341;
            4'd8:    res = 15'd2048;
            4'd9:    res = 15'd1821;
            4'd10:   res = 15'd1639;
            4'd11:   res = 15'd1490;
            4'd12:   res = 15'd1366;
            4'd13:   res = 15'd1261;
            4'd14:   res = 15'd1171;
            4'd15:   res = 15'd1093;
            default: res = 15'd16384;
        endcase
        return res;
    endfunction

    function automatic logic [6:0] clamp_sprite(input logic [6:0] v);
        return (v > SPRITE_DIM_MAX) ? SPRITE_DIM_MAX : v;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:   n_cfg.frame_width   = clamp_dim(i_cfg_data);
                CFG_FRAME_HEIGHT:  n_cfg.frame_height  = clamp_dim(i_cfg_data);
                CFG_SPRITE_X:      n_cfg.sprite_x      = $signed(i_cfg_data);
                CFG_SPRITE_Y:      n_cfg.sprite_y      = $signed(i_cfg_data);
                CFG_SCALE_FACTOR: begin
                    n_cfg.scale = (i_cfg_data[3:0] == 4'd0) ? 4'd1 : i_cfg_data[3:0];
                    n_cfg.recip = recip_of(i_cfg_data[3:0]);
                end
                CFG_SPRITE_WIDTH:  n_cfg.sprite_width  = clamp_sprite(i_cfg_data[6:0]);
                CFG_SPRITE_HEIGHT: n_cfg.sprite_height = clamp_sprite(i_cfg_data[6:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width   <= 13'd640;
            r_cfg.frame_height  <= 13'd480;
            r_cfg.sprite_x      <= 13'sd0;
            r_cfg.sprite_y      <= 13'sd0;
            r_cfg.scale         <= 4'd1;
            r_cfg.recip         <= 15'd16384;
            r_cfg.sprite_width  <= SPRITE_DIM_MAX;
            r_cfg.sprite_height <= SPRITE_DIM_MAX;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/sao_raster.sv
// Raster counters, sprite coverage test and reciprocal texel coordinate stage.
module sao_raster #(
    parameter int MAX_FRAME_DIM = sao_pkg::MAX_FRAME_DIM_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sao_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  sao_pkg::t_in_word i_word,
    output logic              o_valid,
    input  logic              i_ready,
    output sao_pkg::t_s2      o_s2
);
    import sao_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_DIM);
    localparam int EW = ((CW > 13) ? CW : 13) + 1;
    localparam int DW = EW + 1;
    localparam int PW = SPAN_W + RECIP_W;

    logic [CW-1:0] r_col, r_row, n_col, n_row;
    logic [CW-1:0] w_col, w_row;
    logic          r_v1, r_v2;
    t_s1           r_s1;
    t_s2           r_s2;

    logic          w_ready1, w_ready2, w_acc, w_pix;
    logic          w_last_col, w_last_row, w_hit;
    logic signed [DW-1:0] w_dx, w_dy;
    logic [10:0]   w_span_x, w_span_y;
    logic [PW-1:0] w_px, w_py;

    assign w_ready2 = !r_v2 || i_ready;
    assign w_ready1 = !r_v1 || w_ready2;
    assign o_ready  = w_ready1;
    assign w_acc    = i_valid && w_ready1;
    assign w_pix    = (i_word.opcode == OP_PIXEL);

    // A frame start puts this pixel at the top-left corner.
    assign w_col = i_word.frame_start ? '0 : r_col;
    assign w_row = i_word.frame_start ? '0 : r_row;

    assign w_last_col = (EW'(w_col) + EW'(1)) >= EW'(i_cfg.frame_width);
    assign w_last_row = (EW'(w_row) + EW'(1)) >= EW'(i_cfg.frame_height);

    assign w_dx = $signed({{(DW-CW){1'b0}}, w_col}) - DW'(i_cfg.sprite_x);
    assign w_dy = $signed({{(DW-CW){1'b0}}, w_row}) - DW'(i_cfg.sprite_y);

    assign w_span_x = 11'(i_cfg.sprite_width) * 11'(i_cfg.scale);
    assign w_span_y = 11'(i_cfg.sprite_height) * 11'(i_cfg.scale);

    assign w_hit = w_pix && !w_dx[DW-1] && !w_dy[DW-1]
                   && ($unsigned(w_dx) < DW'(w_span_x))
                   && ($unsigned(w_dy) < DW'(w_span_y));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_acc && w_pix) begin
            if (!w_last_col) begin
                n_col = w_col + CW'(1);
                n_row = w_row;
            end else begin
                n_col = '0;
                n_row = w_last_row ? '0 : (w_row + CW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (w_ready1) begin
                r_v1 <= i_valid;
            end
            if (w_ready2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Quotient by the scale as a multiply with a rounded-up reciprocal.
    assign w_px = PW'(r_s1.dx) * PW'(i_cfg.recip);
    assign w_py = PW'(r_s1.dy) * PW'(i_cfg.recip);

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1.is_pix    <= w_pix;
            r_s1.hit       <= w_hit;
            r_s1.frame_end <= w_last_col && w_last_row;
            r_s1.data      <= i_word.pixel_data;
            r_s1.taddr     <= i_word.texel_addr;
            r_s1.dx        <= w_dx[SPAN_W-1:0];
            r_s1.dy        <= w_dy[SPAN_W-1:0];
        end
        if (w_ready2 && r_v1) begin
            r_s2.is_pix    <= r_s1.is_pix;
            r_s2.hit       <= r_s1.hit;
            r_s2.frame_end <= r_s1.frame_end;
            r_s2.data      <= r_s1.data;
            r_s2.taddr     <= r_s1.taddr;
            r_s2.scol      <= w_px[RECIP_SHIFT +: COORD_W];
            r_s2.srow      <= w_py[RECIP_SHIFT +: COORD_W];
        end
    end

    assign o_valid = r_v2;
    assign o_s2    = r_s2;

    a_start_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_pix && i_word.frame_start && !w_last_col)
        |=> (r_col == CW'(1) && r_row == '0))
        else $error("frame start did not restart the raster counters");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_pix && w_last_col && w_last_row)
        |=> (r_col == '0 && r_row == '0))
        else $error("raster counters did not wrap after the last pixel");

endmodule

// File: rtl/core/sao_store.sv
// Sprite texel memory: load words write it, covered pixels read it.
module sao_store #(
    parameter int SPRITE_TEXELS = sao_pkg::SPRITE_TEXELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sao_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  sao_pkg::t_s2  i_s2,
    output logic          o_valid,
    input  logic          i_ready,
    output sao_pkg::t_s3  o_s3,
    output logic [31:0]   o_texel
);
    import sao_pkg::*;

    localparam int AW = $clog2(SPRITE_TEXELS);

    logic [31:0]      mem [SPRITE_TEXELS];
    logic [31:0]      r_texel;
    logic             r_v3;
    t_s3              r_s3;

    logic [IDX_W-1:0] w_idx;
    logic             w_idx_ok, w_load_ok, w_take;
    logic [AW-1:0]    w_addr;

    assign w_idx     = IDX_W'(i_s2.srow) * IDX_W'(i_cfg.sprite_width) + IDX_W'(i_s2.scol);
    assign w_idx_ok  = 32'(w_idx) < 32'(SPRITE_TEXELS);
    assign w_load_ok = 32'(i_s2.taddr) < 32'(SPRITE_TEXELS);
    assign w_addr    = i_s2.is_pix ? AW'(w_idx) : AW'(i_s2.taddr);

    // Loads and reads share one port and stay in stream order, so a pixel
    // always sees every load that came before it.
    assign o_ready = !r_v3 || i_ready;
    assign w_take  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (!i_s2.is_pix) begin
                if (w_load_ok) begin
                    mem[w_addr] <= i_s2.data;
                end
            end else begin
                r_texel <= mem[w_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (o_ready) begin
            r_v3 <= i_valid && i_s2.is_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_s2.is_pix) begin
            r_s3.hit       <= i_s2.hit;
            r_s3.frame_end <= i_s2.frame_end;
            r_s3.tex_ok    <= i_s2.hit && w_idx_ok;
            r_s3.data      <= i_s2.data;
        end
    end

    assign o_valid = r_v3;
    assign o_s3    = r_s3;
    assign o_texel = r_texel;

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !i_s2.is_pix) |=> !r_v3)
        else $error("a texel load produced a pixel word");

endmodule

// File: rtl/core/sao_blend.sv
// Alpha compositing of the fetched texel over the destination pixel, output register.
module sao_blend (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sao_pkg::t_s3       i_s3,
    input  logic [31:0]        i_texel,
    output logic               o_valid,
    input  logic               i_ready,
    output sao_pkg::t_out_word o_word
);
    import sao_pkg::*;

    logic        r_ov;
    t_out_word   r_word;

    logic        w_take;
    logic [31:0] w_src, w_mix, w_blended, n_pixel;
    logic [7:0]  w_alpha, w_ialpha;
    logic [16:0] w_sum [3];

    assign o_ready = !r_ov || i_ready;
    assign w_take  = i_valid && o_ready;

    // A texel index past the store reads as transparent.
    assign w_src    = i_s3.tex_ok ? i_texel : '0;
    assign w_alpha  = w_src[31:24];
    assign w_ialpha = ALPHA_OPAQUE - w_alpha;

    always_comb begin
        w_mix = '0;
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = 17'(w_src[8*c +: 8]) * 17'(w_alpha)
                     + 17'(i_s3.data[8*c +: 8]) * 17'(w_ialpha);
            w_mix[8*c +: 8] = w_sum[c][15:8];
        end
        w_mix[31:24] = ALPHA_CLEAR;
    end

    always_comb begin
        unique if (w_alpha == ALPHA_CLEAR) begin
            w_blended = i_s3.data;
        end else if (w_alpha == ALPHA_OPAQUE) begin
            w_blended = w_src & RGB_MASK;
        end else begin
            w_blended = w_mix;
        end
    end

    assign n_pixel = i_s3.hit ? w_blended : i_s3.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_ready) begin
            r_ov <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_word.pixel_out  <= n_pixel;
            r_word.sprite_hit <= i_s3.hit;
            r_word.frame_end  <= i_s3.frame_end;
        end
    end

    assign o_valid = r_ov;
    assign o_word  = r_word;

    a_miss_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !i_s3.hit) |=> (r_word.pixel_out == $past(i_s3.data)))
        else $error("uncovered pixel was altered");

    a_bad_index_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_s3.hit && !i_s3.tex_ok) |=> (r_word.pixel_out == $past(i_s3.data)))
        else $error("pixel over an out-of-range texel was altered");

endmodule

// File: rtl/core/scaled_sprite_alpha_overlay_top.sv
// Scaled sprite alpha overlay: raster, sprite memory and compositing pipeline.
// Pipeline: a pixel word passes the coverage, texel coordinate, memory read and
// output registers in order before it shows on o_out_valid. Throughput: one word
// per cycle while i_out_stall is low, loads and pixels alike; the single-port
// sprite memory takes one access per cycle. Loads produce no output word.
// Reset: configuration returns to its defaults, raster counters go to zero and the
// pipeline empties; the sprite memory is not cleared and must be loaded first.
module scaled_sprite_alpha_overlay_top #(
    parameter int SPRITE_TEXELS = sao_pkg::SPRITE_TEXELS_DEF,
    parameter int MAX_FRAME_DIM = sao_pkg::MAX_FRAME_DIM_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sao_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sao_pkg::t_out_word             o_out_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sao_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sao_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sao_pkg::*;

    t_cfg        w_cfg;
    logic        w_raster_ready;
    logic        w_s2_valid, w_s2_ready;
    t_s2         w_s2;
    logic        w_s3_valid, w_s3_ready;
    t_s3         w_s3;
    logic [31:0] w_texel;

    sao_cfg #(
        .MAX_FRAME_DIM (MAX_FRAME_DIM)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    sao_raster #(
        .MAX_FRAME_DIM (MAX_FRAME_DIM)
    ) u_raster (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_in_valid),
        .o_ready (w_raster_ready),
        .i_word  (i_in_word),
        .o_valid (w_s2_valid),
        .i_ready (w_s2_ready),
        .o_s2    (w_s2)
    );

    sao_store #(
        .SPRITE_TEXELS (SPRITE_TEXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_s2_valid),
        .o_ready (w_s2_ready),
        .i_s2    (w_s2),
        .o_valid (w_s3_valid),
        .i_ready (w_s3_ready),
        .o_s3    (w_s3),
        .o_texel (w_texel)
    );

    sao_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s3_valid),
        .o_ready (w_s3_ready),
        .i_s3    (w_s3),
        .i_texel (w_texel),
        .o_valid (o_out_valid),
        .i_ready (!i_out_stall),
        .o_word  (o_out_word)
    );

    assign o_in_stall = !w_raster_ready;

endmodule

// File: dv/scaled_sprite_alpha_overlay_top_test.sv
// Self-checking testbench of the scaled sprite alpha overlay, with random stimulus.
module scaled_sprite_alpha_overlay_top_test;
    import sao_pkg::*;

    localparam int CYCLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 250;
    localparam int TEXELS_FILLED = 64;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_word              i_in_word = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Words waiting to be offered, and the composited pixels still owed by the block.
    t_in_word  words_to_send[$];
    t_out_word pixels_due[$];

    // Mirror of the overlay: register values as written, texel store and raster position.
    logic [12:0]        frame_w_reg = 13'd640;
    logic [12:0]        frame_h_reg = 13'd480;
    logic signed [12:0] sprite_x_reg = '0;
    logic signed [12:0] sprite_y_reg = '0;
    logic [3:0]         scale_reg = 4'd1;
    logic [6:0]         sprite_w_reg = 7'd64;
    logic [6:0]         sprite_h_reg = 7'd64;
    logic [31:0]        texel_mirror [SPRITE_TEXELS_DEF];
    int                 raster_col = 0;
    int                 raster_row = 0;

    int   cycle_count = 0;
    int   mismatch_count = 0;
    int   random_sent = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic in_taken = 1'b0;
    logic no_gaps;

    scaled_sprite_alpha_overlay_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Both sides run without gaps while no_gaps is set, a window that recurs with cycle_count.
    assign no_gaps = (cycle_count % 1000) >= 400 && (cycle_count % 1000) < 600;

    function automatic logic [31:0] alpha_mix(logic [31:0] src, logic [31:0] dst);
        logic [7:0]  a;
        logic [31:0] mixed;
        int          ch;
        int          sum;
        a = src[31:24];
        if (a == ALPHA_CLEAR) return dst;
        if (a == ALPHA_OPAQUE) return src & RGB_MASK;
        mixed = '0;
        for (ch = 0; ch < 3; ch++) begin
            sum = int'(src[ch*8 +: 8]) * int'(a)
                + int'(dst[ch*8 +: 8]) * (int'(ALPHA_OPAQUE) - int'(a));
            mixed[ch*8 +: 8] = 8'(sum >> 8);
        end
        return mixed;
    endfunction

    function automatic int clamp_frame(logic [12:0] v);
        if (v == 0) return 1;
        return (int'(v) > MAX_FRAME_DIM_DEF) ? MAX_FRAME_DIM_DEF : int'(v);
    endfunction

    function automatic int clamp_sprite(logic [6:0] v);
        return (v > SPRITE_DIM_MAX) ? int'(SPRITE_DIM_MAX) : int'(v);
    endfunction

    task automatic overlay_step(input t_in_word w);
        int          fw, fh, sc, sw, sh, dx, dy, idx;
        logic [31:0] texel;
        t_out_word   r;
        if (w.opcode == OP_LOAD) begin
            texel_mirror[w.texel_addr] = w.pixel_data;
            return;
        end
        if (w.frame_start) begin
            raster_col = 0;
            raster_row = 0;
        end
        fw = clamp_frame(frame_w_reg);
        fh = clamp_frame(frame_h_reg);
        sc = (scale_reg == 0) ? 1 : int'(scale_reg);
        sw = clamp_sprite(sprite_w_reg);
        sh = clamp_sprite(sprite_h_reg);
        dx = raster_col - int'(sprite_x_reg);
        dy = raster_row - int'(sprite_y_reg);
        r.pixel_out = w.pixel_data;
        r.sprite_hit = 1'b0;
        if (dx >= 0 && dy >= 0 && dx < sw * sc && dy < sh * sc) begin
            idx = (dy / sc) * sw + dx / sc;
            texel = (idx < SPRITE_TEXELS_DEF) ? texel_mirror[idx] : '0;
            r.pixel_out = alpha_mix(texel, w.pixel_data);
            r.sprite_hit = 1'b1;
        end
        r.frame_end = (raster_col + 1 >= fw) && (raster_row + 1 >= fh);
        pixels_due.push_back(r);
        // A column or row at or past a shrunken limit still ends its row or frame.
        if (raster_col + 1 < fw) begin
            raster_col++;
        end else begin
            raster_col = 0;
            raster_row = (raster_row + 1 >= fh) ? 0 : raster_row + 1;
        end
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (pixels_due.size() == 0) begin
            note_mismatch($sformatf("output word %h arrived with nothing expected", got));
            return;
        end
        want = pixels_due.pop_front();
        if (got.pixel_out !== want.pixel_out)
            note_mismatch($sformatf("pixel_out %h, expected %h", got.pixel_out, want.pixel_out));
        if (got.sprite_hit !== want.sprite_hit)
            note_mismatch($sformatf("sprite_hit %b, expected %b", got.sprite_hit,
                want.sprite_hit));
        if (got.frame_end !== want.frame_end)
            note_mismatch($sformatf("frame_end %b, expected %b", got.frame_end, want.frame_end));
    endtask

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) overlay_step(i_in_word);
        if (i_rst_n && o_out_valid && !i_out_stall) check_word(o_out_word);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (words_to_send.size() != 0 && (no_gaps || $urandom_range(99) >= 22)) begin
                i_in_word <= words_to_send.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // One long hold-off of the output side while pixels are still queued, so that the
    // pipeline fills and stalls its input.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && o_out_valid && words_to_send.size() >= 20) begin
            hold_left <= 150;
            hold_done <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= (hold_left != 0) || (!no_gaps && $urandom_range(99) < 22);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_texel();
        logic [7:0] a;
        case ($urandom_range(3))
            0: a = ALPHA_CLEAR;
            1: a = ALPHA_OPAQUE;
            default: a = 8'($urandom_range(254, 1));
        endcase
        return {a, 24'($urandom)};
    endfunction

    function automatic t_in_word pix_word(logic start, logic [31:0] data);
        t_in_word w;
        w.opcode = OP_PIXEL;
        w.texel_addr = TADDR_W'($urandom);
        w.pixel_data = data;
        w.frame_start = start;
        return w;
    endfunction

    function automatic t_in_word load_word(logic [TADDR_W-1:0] addr, logic [31:0] data);
        t_in_word w;
        w.opcode = OP_LOAD;
        w.texel_addr = addr;
        w.pixel_data = data;
        w.frame_start = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic int pick_dim();
        int r;
        r = $urandom_range(19);
        if (r < 14) return $urandom_range(8, 1);
        if (r < 17) return 0;
        return $urandom_range(127, 9);
    endfunction

    // Loads leave no result, so the block gets extra cycles after the last pixel.
    task automatic wait_quiet(input int settle);
        while (words_to_send.size() != 0 || i_in_valid || pixels_due.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FRAME_WIDTH:   frame_w_reg = val;
            CFG_FRAME_HEIGHT:  frame_h_reg = val;
            CFG_SPRITE_X:      sprite_x_reg = val;
            CFG_SPRITE_Y:      sprite_y_reg = val;
            CFG_SCALE_FACTOR:  scale_reg = val[3:0];
            CFG_SPRITE_WIDTH:  sprite_w_reg = val[6:0];
            CFG_SPRITE_HEIGHT: sprite_h_reg = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_overlay(input int fw, input int fh, input int sx, input int sy,
                               input int sc, input int sw, input int sh);
        wait_quiet(8);
        put_reg(CFG_FRAME_WIDTH, 13'(fw));
        put_reg(CFG_FRAME_HEIGHT, 13'(fh));
        put_reg(CFG_SPRITE_X, 13'(sx));
        put_reg(CFG_SPRITE_Y, 13'(sy));
        put_reg(CFG_SCALE_FACTOR, 13'(sc));
        put_reg(CFG_SPRITE_WIDTH, 13'(sw));
        put_reg(CFG_SPRITE_HEIGHT, 13'(sh));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic push_pixels(input int count);
        int k;
        for (k = 0; k < count; k++)
            words_to_send.push_back(pix_word(k == 0, $urandom));
    endtask

    // One random setting followed by a frame or two of pixels with loads mixed in.
    task automatic random_scene();
        int fw, fh, sc, sw, sh, sx, sy, len, k;
        bit fresh;
        fw = ($urandom_range(19) == 0) ? 0 : $urandom_range(16, 1);
        fh = ($urandom_range(19) == 0) ? 0 : $urandom_range(8, 1);
        sc = $urandom_range(1) ? $urandom_range(3) : $urandom_range(15);
        sw = pick_dim();
        sh = pick_dim();
        // Every fetched index stays below width times height, so keep that inside the
        // filled part of the store.
        if (clamp_sprite(7'(sw)) * clamp_sprite(7'(sh)) > TEXELS_FILLED) begin
            if ($urandom_range(1)) sh = TEXELS_FILLED / clamp_sprite(7'(sw));
            else sw = TEXELS_FILLED / clamp_sprite(7'(sh));
        end
        if ($urandom_range(9) == 0) begin
            sx = int'($urandom_range(8191)) - 4096;
            sy = int'($urandom_range(8191)) - 4096;
        end else begin
            sx = int'($urandom_range(40)) - 20;
            sy = int'($urandom_range(24)) - 12;
        end
        set_overlay(fw, fh, sx, sy, sc, sw, sh);
        // Now and then the raster carries on from the previous setting.
        fresh = $urandom_range(4) != 0;
        len = (fw == 0 ? 1 : fw) * (fh == 0 ? 1 : fh) * $urandom_range(2, 1)
            + $urandom_range(3);
        if (len > 150) len = 150;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0) begin
                words_to_send.push_back(load_word(
                    TADDR_W'($urandom_range(3) != 0 ? $urandom_range(63)
                                                   : $urandom_range(4095)),
                    rand_texel()));
                random_sent++;
            end
            words_to_send.push_back(pix_word((k == 0 && fresh) || $urandom_range(49) == 0,
                $urandom));
            random_sent++;
        end
    endtask

    initial begin
        int a;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the part of the store that any fetch can reach, so that no fetch ever
        // reads an unwritten texel.
        for (a = 0; a < TEXELS_FILLED; a++)
            words_to_send.push_back(load_word(TADDR_W'(a), rand_texel()));

        // Default setting: 64x64 sprite at the origin, scale one.
        words_to_send.push_back(load_word(12'd1, 32'h0012_3456));
        words_to_send.push_back(load_word(12'd2, 32'hFFAB_CDEF));
        words_to_send.push_back(load_word(12'd3, 32'h80FF_00FF));
        words_to_send.push_back(load_word(12'd4095, 32'hFFFF_FFFF));
        words_to_send.push_back(load_word(12'd0, 32'h0000_0000));
        words_to_send.push_back(pix_word(1'b1, 32'hFFFF_FFFF));
        words_to_send.push_back(pix_word(1'b0, 32'h0000_0000));
        words_to_send.push_back(pix_word(1'b0, 32'h1234_5678));
        words_to_send.push_back(pix_word(1'b0, 32'h0000_0000));
        // A load right before the pixel that fetches the same texel.
        words_to_send.push_back(load_word(12'd4, 32'h7F0A_0B0C));
        words_to_send.push_back(pix_word(1'b0, 32'hFFFF_FFFF));
        words_to_send.push_back(pix_word(1'b0, 32'hFFFF_FFFF));
        words_to_send.push_back(pix_word(1'b1, 32'h0000_0000));
        words_to_send.push_back(pix_word(1'b0, 32'hA5A5_5A5A));

        // Widest frame, clamped from the register maximum, so no row ends here.
        set_overlay(8191, 0, 2, 0, 15, 127, 1);
        push_pixels(40);
        // Tallest frame, one pixel wide, sprite clipped at the top.
        set_overlay(1, 4096, 0, -40, 2, 1, 64);
        push_pixels(40);
        // Most negative placement and an empty sprite.
        set_overlay(5, 3, -4096, -4096, 0, 0, 0);
        push_pixels(20);
        set_overlay(6, 4, 4095, 4095, 1, 64, 64);
        push_pixels(26);
        // Partly off the top-left corner, zero scale acting as one.
        set_overlay(7, 5, -3, -2, 0, 4, 4);
        push_pixels(36);

        while (random_sent < RANDOM_ITEMS) random_scene();

        wait_quiet(16);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/sao_pkg.sv
rtl/core/sao_cfg.sv
rtl/core/sao_raster.sv
rtl/core/sao_store.sv
rtl/core/sao_blend.sv
rtl/core/scaled_sprite_alpha_overlay_top.sv
dv/scaled_sprite_alpha_overlay_top_test.sv
